@@ rtl/tlv_status_field_encoder_macros.svh @@
// Assertion macros for the TLV status field encoder checker.
// Depends on nothing; included by the checker file only.
`ifndef TLV_STATUS_FIELD_ENCODER_MACROS_SVH
`define TLV_STATUS_FIELD_ENCODER_MACROS_SVH

// Implication checked in the next cycle, disabled while reset is high.
`define TSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tse checker: property failed");

// Implication checked in the next cycle, also checked across reset.
`define TSE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tse checker: property failed after reset");

`endif

@@ rtl/tse_pkg.sv @@
// Shared types and constants of the TLV status field encoder.
// Depends on nothing; used by the front end, queue, back end and top level.
package tse_pkg;

   localparam int MAX_BYTES = 10;
   localparam int CNT_W     = 4;
   localparam int IDX_W     = 4;

   typedef enum logic [2:0] {
      OP_INT     = 3'd0,
      OP_SINGLE  = 3'd1,
      OP_DOUBLE  = 3'd2,
      OP_END     = 3'd3,
      OP_STRING  = 3'd4,
      OP_VECTOR  = 3'd5,
      OP_PAYLOAD = 3'd6,
      OP_ELEMENT = 3'd7
   } op_type;

   localparam logic [7:0]  LEN_LONG    = 8'h80;
   localparam logic [31:0] SHORT_LIMIT = 32'd128;
   localparam logic [31:0] LIMIT_2B    = 32'd65536;
   localparam logic [31:0] LIMIT_3B    = 32'd16777216;
   localparam int          TOP_SHIFT   = 56;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ rtl/tse_if.sv @@
// Channel interfaces of the TLV status field encoder: request and response.
// Depends on nothing.
interface tse_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [7:0]  tag;
   logic [63:0] value;

   modport source (output valid, output operation, output tag, output value, input ready);
   modport sink   (input valid, input operation, input tag, input value, output ready);
endinterface

interface tse_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ rtl/tse_front.sv @@
// Front end: accepts request items and classifies them into byte descriptors.
// Depends on tse_pkg and tse_req_if.
module tse_front (
   tse_req_if.sink            req,
   input  tse_pkg::q_status_type q_status,
   output logic               push,
   output tse_pkg::desc_type  push_desc
);
   import tse_pkg::*;

   op_type      op;
   logic [63:0] ival;
   logic [63:0] ishift;
   logic [3:0]  ilen;
   logic        nan;
   logic [31:0] hlen;
   logic [31:0] hshift;
   logic [2:0]  nb;

   assign op = op_type'(req.operation);
   assign req.ready = !q_status.full;
   assign push = req.valid && req.ready && (push_desc.count != '0);

   assign ival = (op == OP_SINGLE) ? {32'd0, req.value[31:0]} : req.value;
   assign nan  = ((op == OP_SINGLE) && (req.value[30:23] == 8'hFF) && (req.value[22:0] != '0))
              || ((op == OP_DOUBLE) && (req.value[62:52] == 11'h7FF)
                  && (req.value[51:0] != '0));

   always_comb begin
      ilen = '0;
      for (int k = 0; k < 8; k++) begin
         if (ival[8*k +: 8] != '0) begin
            ilen = 4'(k + 1);
         end
      end
   end

   assign ishift = ival << 7'({4'd8 - ilen, 3'b000});

   assign hlen = (op == OP_VECTOR) ? {req.value[29:0], 2'b00} : req.value[31:0];
   assign nb   = (hlen < LIMIT_2B) ? 3'd2 : ((hlen < LIMIT_3B) ? 3'd3 : 3'd4);
   assign hshift = hlen << 6'({3'd4 - nb, 3'b000});

   always_comb begin
      push_desc = '0;
      unique case (op)
         OP_INT, OP_SINGLE, OP_DOUBLE: begin
            if (!nan) begin
               push_desc.bytes[0] = req.tag;
               push_desc.bytes[1] = {4'd0, ilen};
               for (int k = 0; k < 8; k++) begin
                  push_desc.bytes[2 + k] = ishift[TOP_SHIFT - 8*k +: 8];
               end
               push_desc.count = CNT_W'(2) + ilen;
            end
         end
         OP_END: begin
            push_desc.count = CNT_W'(1);
         end
         OP_STRING, OP_VECTOR: begin
            push_desc.bytes[0] = req.tag;
            if (hlen < SHORT_LIMIT) begin
               push_desc.bytes[1] = hlen[7:0];
               push_desc.count    = CNT_W'(2);
            end else begin
               push_desc.bytes[1] = LEN_LONG | {5'd0, nb};
               for (int k = 0; k < 4; k++) begin
                  push_desc.bytes[2 + k] = hshift[24 - 8*k +: 8];
               end
               push_desc.count = CNT_W'(2) + {1'b0, nb};
            end
         end
         OP_PAYLOAD: begin
            push_desc.bytes[0] = req.value[7:0];
            push_desc.count    = CNT_W'(1);
         end
         OP_ELEMENT: begin
            for (int k = 0; k < 4; k++) begin
               push_desc.bytes[k] = req.value[24 - 8*k +: 8];
            end
            push_desc.count = CNT_W'(4);
         end
         default: begin
            push_desc = '0;
         end
      endcase
   end

endmodule

@@ rtl/tse_queue.sv @@
// Two-entry descriptor queue between the front and the back end.
// Depends on tse_pkg.
module tse_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tse_pkg::desc_type     push_desc,
   input  logic                  pop,
   output tse_pkg::desc_type     head,
   output tse_pkg::q_status_type q_status
);
   import tse_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == 2'd2);
   assign q_status.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

@@ rtl/tse_back.sv @@
// Back end: walks the head descriptor and presents one byte per transfer.
// Depends on tse_pkg and tse_rsp_if.
module tse_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tse_pkg::desc_type     head,
   input  tse_pkg::q_status_type q_status,
   output logic                  pop,
   tse_rsp_if.source             rsp
);
   import tse_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff;
   logic             last_ff;
   logic             advance;
   logic             load;
   logic             cur_last;

   assign advance  = !valid_ff || rsp.ready;
   assign load     = advance && !q_status.empty;
   assign cur_last = (idx_ff == (head.count - CNT_W'(1)));
   assign pop      = load && cur_last;

   assign rsp.valid    = valid_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.last     = last_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = !q_status.empty;
      end
      if (load) begin
         idx_in = cur_last ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // hold the byte until it is taken
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= head.bytes[idx_ff];
         last_ff <= cur_last;
      end
   end

endmodule

@@ rtl/tlv_status_field_encoder.sv @@
// Channel   Dir  Handshake    Payload
// req       in   valid/ready  operation[2:0], tag[7:0], value[63:0]
// rsp       out  valid/ready  out_byte[7:0], last
// An item yields 0 to 10 bytes; the back end sends one byte per cycle while rsp.ready is
// high; a queued item holds 1 to 10 bytes.
// After acceptance, the first byte is registered into the queue, then into rsp.
// The two-entry queue takes new items while the output stalls; req.ready drops when full.
// Reset is synchronous and empties the queue and the output register.
// Top level of the TLV status field encoder. Depends on tse_pkg, tse_if, tse_front,
// tse_queue and tse_back.
module tlv_status_field_encoder (
   input  logic      clock,
   input  logic      reset,
   tse_req_if.sink   req,
   tse_rsp_if.source rsp
);
   import tse_pkg::*;

   q_status_type q_status;
   desc_type     push_desc;
   desc_type     head;
   logic         push;
   logic         pop;

   tse_front u_front (
      .req       (req),
      .q_status  (q_status),
      .push      (push),
      .push_desc (push_desc)
   );

   tse_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .q_status  (q_status)
   );

   tse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

@@ rtl/tse_checker.sv @@
// Port-level checker of the TLV status field encoder, bound to the top level.
// Depends on tlv_status_field_encoder_macros.svh.
`include "tlv_status_field_encoder_macros.svh"

module tse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   `TSE_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TSE_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_out_byte) && $stable(rsp_last))
   `TSE_ASSERT_NEXT(a_no_gap_in_item, clock, reset, rsp_valid && rsp_ready && !rsp_last,
      rsp_valid)
   `TSE_ASSERT_NEXT_ALWAYS(a_reset_state, clock, reset, req_ready && !rsp_valid)

endmodule

bind tlv_status_field_encoder tse_checker u_tse_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_out_byte (rsp.out_byte),
   .rsp_last     (rsp.last)
);

@@ test/tse_stream_checker.sv @@
`timescale 1ns / 1ps
// Stream checker for the TLV status field encoder: encodes every request transfer into
// the bytes it must produce and compares each response transfer with the oldest one.
// Depends on tse_pkg and the channel interfaces in tse_if.
module tse_stream_checker (
   input  logic clock,
   input  logic reset,
   tse_req_if   req,
   tse_rsp_if   rsp,
   output int   mismatches,
   output int   bytes_waiting,
   output int   bytes_compared
);
   import tse_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   stream_byte_type expected_stream[$];
   stream_byte_type head;
   int              item_bytes;

   function automatic void emit_byte(input logic [7:0] b);
      stream_byte_type e;
      e.data = b;
      e.last = 1'b0;
      expected_stream.push_back(e);
      item_bytes++;
   endfunction

   function automatic void emit_trimmed(input logic [7:0] tag, input logic [63:0] x);
      logic [63:0] v;
      int          len;
      v   = x;
      len = 8;
      emit_byte(tag);
      if (v == 64'd0) begin
         emit_byte(8'd0);
      end else begin
         while (8'(v >> TOP_SHIFT) == 8'd0) begin
            v = v << 8;
            len--;
         end
         emit_byte(8'(len));
         for (int i = 0; i < len; i++) begin
            emit_byte(8'(v >> TOP_SHIFT));
            v = v << 8;
         end
      end
   endfunction

   function automatic void emit_header(input logic [7:0] tag, input logic [31:0] len);
      int nb;
      emit_byte(tag);
      if (len < SHORT_LIMIT) begin
         emit_byte(len[7:0]);
      end else begin
         if (len < LIMIT_2B) begin
            nb = 2;
         end else if (len < LIMIT_3B) begin
            nb = 3;
         end else begin
            nb = 4;
         end
         emit_byte(LEN_LONG | 8'(nb));
         for (int i = nb - 1; i >= 0; i--) begin
            emit_byte(8'(len >> (8 * i)));
         end
      end
   endfunction

   function automatic void encode_request(input op_type op, input logic [7:0] tag,
                                          input logic [63:0] value);
      item_bytes = 0;
      case (op)
         OP_INT: begin
            emit_trimmed(tag, value);
         end
         OP_SINGLE: begin
            if (!(value[30:23] == 8'hFF && value[22:0] != 23'd0)) begin
               emit_trimmed(tag, {32'd0, value[31:0]});
            end
         end
         OP_DOUBLE: begin
            if (!(value[62:52] == 11'h7FF && value[51:0] != 52'd0)) begin
               emit_trimmed(tag, value);
            end
         end
         OP_END: begin
            emit_byte(8'h00);
         end
         OP_STRING: begin
            emit_header(tag, value[31:0]);
         end
         OP_VECTOR: begin
            emit_header(tag, {value[29:0], 2'b00});
         end
         OP_PAYLOAD: begin
            emit_byte(value[7:0]);
         end
         default: begin
            emit_byte(value[31:24]);
            emit_byte(value[23:16]);
            emit_byte(value[15:8]);
            emit_byte(value[7:0]);
         end
      endcase
      if (item_bytes > 0) begin
         expected_stream[expected_stream.size() - 1].last = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            encode_request(op_type'(req.operation), req.tag, req.value);
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_stream.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected byte %02h last %0b with nothing pending",
                           rsp.out_byte, rsp.last);
               end
            end else begin
               head = expected_stream.pop_front();
               bytes_compared++;
               if (rsp.out_byte !== head.data || rsp.last !== head.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                              head.data, head.last, rsp.out_byte, rsp.last);
                  end
               end
            end
         end
      end
      bytes_waiting = expected_stream.size();
   end

endmodule

@@ test/tb_tlv_status_field_encoder.sv @@
`timescale 1ns / 1ps
// Testbench top of the TLV status field encoder: drives requests and response back-pressure
// and gives the verdict. Depends on tse_pkg, tse_if, tse_stream_checker and the block.
module tb_tlv_status_field_encoder;
   import tse_pkg::*;

   logic clock = 1'b0;
   logic reset;
   int   mismatches;
   int   bytes_waiting;
   int   bytes_compared;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   items_sent;

   tse_req_if req_ch ();
   tse_rsp_if rsp_ch ();

   tlv_status_field_encoder dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   tse_stream_checker stream_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .mismatches     (mismatches),
      .bytes_waiting  (bytes_waiting),
      .bytes_compared (bytes_compared)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_request(input op_type op, input logic [7:0] tag,
                               input logic [63:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.tag       <= tag;
      req_ch.value     <= value;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   function automatic logic [63:0] wide_value();
      logic [63:0] r;
      r = {$urandom, $urandom};
      if ($urandom_range(15) == 0) begin
         r = 64'd0;
      end
      return r >> $urandom_range(63);
   endfunction

   function automatic logic [63:0] float_bits(input bit dbl);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(3))
         0: begin
            if (dbl) r[62:52] = '1; else r[30:23] = '1;
         end
         1: begin
            if (dbl) begin
               r[62:52] = '1;
               r[51:0]  = '0;
            end else begin
               r[30:23] = '1;
               r[22:0]  = '0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_random(input int target);
      int goal;
      int n;
      goal = items_sent + target;
      while (items_sent < goal) begin
         case ($urandom_range(9))
            0, 1: send_request(OP_INT, 8'($urandom), wide_value());
            2: send_request(OP_SINGLE, 8'($urandom), float_bits(1'b0));
            3: send_request(OP_DOUBLE, 8'($urandom), float_bits(1'b1));
            4, 5: begin
               if ($urandom_range(3) == 0) begin
                  send_request(OP_STRING, 8'($urandom), wide_value());
               end else begin
                  n = $urandom_range(6);
                  send_request(OP_STRING, 8'($urandom), {32'($urandom), 32'(n)});
                  repeat (n) send_request(OP_PAYLOAD, 8'($urandom), {$urandom, $urandom});
               end
            end
            6, 7: begin
               if ($urandom_range(3) == 0) begin
                  send_request(OP_VECTOR, 8'($urandom), wide_value());
               end else begin
                  n = $urandom_range(3);
                  send_request(OP_VECTOR, 8'($urandom),
                               {32'($urandom), 2'($urandom), 30'(n)});
                  repeat (n) send_request(OP_ELEMENT, 8'($urandom), {$urandom, $urandom});
               end
            end
            8: send_request(OP_END, 8'($urandom), {$urandom, $urandom});
            default: send_request(op_type'(3'($urandom_range(7))), 8'($urandom),
                                  {$urandom, $urandom});
         endcase
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = 3'd0;
      req_ch.tag       = 8'd0;
      req_ch.value     = 64'd0;
      rsp_ch.ready     = 1'b0;
      send_idle_pct    = 7;
      recv_idle_pct    = 87;
      items_sent       = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      send_request(OP_INT,     8'h00, 64'h0000_0000_0000_0000);
      send_request(OP_INT,     8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_INT,     8'h01, 64'h0000_0000_0000_0080);
      send_request(OP_INT,     8'h02, 64'h0000_0000_0001_0000);
      send_request(OP_SINGLE,  8'h03, 64'hFFFF_FFFF_3F80_0000);
      send_request(OP_SINGLE,  8'h04, 64'h0000_0000_7FC0_0001);
      send_request(OP_SINGLE,  8'h05, 64'h0000_0000_7F80_0000);
      send_request(OP_SINGLE,  8'h06, 64'hDEAD_BEEF_0000_0000);
      send_request(OP_DOUBLE,  8'h07, 64'h7FF8_0000_0000_0000);
      send_request(OP_DOUBLE,  8'h08, 64'hFFF0_0000_0000_0001);
      send_request(OP_DOUBLE,  8'h09, 64'h7FF0_0000_0000_0000);
      send_request(OP_END,     8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_STRING,  8'h0A, 64'd127);
      send_request(OP_STRING,  8'h0B, 64'd128);
      send_request(OP_STRING,  8'h0C, 64'd65535);
      send_request(OP_STRING,  8'h0D, 64'd65536);
      send_request(OP_STRING,  8'h0E, 64'd16777215);
      send_request(OP_STRING,  8'h0F, 64'd16777216);
      send_request(OP_STRING,  8'h10, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_VECTOR,  8'h11, 64'd31);
      send_request(OP_VECTOR,  8'h12, 64'd32);
      send_request(OP_VECTOR,  8'h13, 64'h0000_0000_4000_0000);
      send_request(OP_VECTOR,  8'h14, 64'h0000_0000_FFFF_FFFF);
      send_request(OP_PAYLOAD, 8'hAA, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(OP_ELEMENT, 8'h55, 64'hFFFF_FFFF_0000_1200);
      send_request(OP_ELEMENT, 8'hFF, 64'h0000_0000_FFFF_FFFF);

      send_random(85);
      send_idle_pct = 87;
      recv_idle_pct <= 7;
      send_random(85);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      send_random(85);
      req_ch.valid <= 1'b0;

      while (bytes_waiting != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("covered %0d requests: field edge cases, then random streams under three pacing",
               items_sent);
      $display("profiles of sender and receiver; %0d response bytes compared", bytes_compared);
      if (mismatches == 0 && bytes_waiting == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout waiting for the encoder");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
